/* rtl/core/dmxrx_pkg.sv */
package dmxrx_pkg;

    // Fixed field widths of the result word and the configuration registers.
    localparam int IDX_W   = 5;
    localparam int PKT_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 10;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 1;

    // Default sizes handed to the top level.
    localparam int DEF_PAYLOAD_BYTES = 30;
    localparam int DEF_MAX_SLOTS     = 512;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] START_ADDRESS_RST = CFG_W'(1);
    localparam logic [CFG_W-1:0] CHANNEL_COUNT_RST = CFG_W'(512);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

    // One output word.
    typedef struct packed {
        logic [PKT_W-1:0]  packet_number;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic              packet_done;
        logic              last_of_run;
    } res_t;

    // Words produced by one input byte, handed from the control to the queue.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } step_t;

endpackage

/* rtl/core/dmxrx_ctrl.sv */
module dmxrx_ctrl #(
    parameter int PAYLOAD_BYTES = dmxrx_pkg::DEF_PAYLOAD_BYTES,
    parameter int MAX_SLOTS     = dmxrx_pkg::DEF_MAX_SLOTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dmxrx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmxrx_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            fire,
    input  logic [dmxrx_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                            frame_error,
    output dmxrx_pkg::step_t                step
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_BREAK = 2'd1,
        ST_START = 2'd2,
        ST_RUN   = 2'd3
    } rx_state_t;

    localparam logic [dmxrx_pkg::IDX_W-1:0]  PAYLOAD_IDX =
        dmxrx_pkg::IDX_W'(PAYLOAD_BYTES);
    localparam logic [dmxrx_pkg::SLOT_W-1:0] MAX_LIMIT =
        dmxrx_pkg::SLOT_W'(MAX_SLOTS);

    rx_state_t                       state_reg, state_next;
    logic [dmxrx_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [dmxrx_pkg::SLOT_W-1:0]    cap_reg, cap_next;
    logic [dmxrx_pkg::PKT_W-1:0]     pkt_reg, pkt_next;
    logic [dmxrx_pkg::IDX_W-1:0]     fill_reg, fill_next;
    logic [dmxrx_pkg::CFG_W-1:0]     start_address_reg;
    logic [dmxrx_pkg::CFG_W-1:0]     channel_count_reg;

    logic                            do_cap;
    logic [dmxrx_pkg::SLOT_W-1:0]    cap_base, cap_inc, limit;
    logic [dmxrx_pkg::PKT_W-1:0]     pkt_base;
    logic [dmxrx_pkg::IDX_W-1:0]     fill_base, fill_inc;

    // A zero channel count means one; counts above the slot limit are clipped.
    always_comb
    begin
        if (channel_count_reg == '0)
            limit = dmxrx_pkg::SLOT_W'(1);
        else if (channel_count_reg > MAX_LIMIT)
            limit = MAX_LIMIT;
        else
            limit = channel_count_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        cap_next   = cap_reg;
        pkt_next   = pkt_reg;
        fill_next  = fill_reg;
        do_cap     = 1'b0;
        cap_base   = cap_reg;
        pkt_base   = pkt_reg;
        fill_base  = fill_reg;
        cap_inc    = '0;
        fill_inc   = '0;
        step       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (frame_error)
                begin
                    slot_next  = '0;
                    state_next = ST_BREAK;
                end
            end
            ST_BREAK:
            begin
                state_next = (rx_byte == '0) ? ST_START : ST_IDLE;
            end
            ST_START:
            begin
                slot_next = slot_reg + dmxrx_pkg::SLOT_W'(1);
                if (slot_next == start_address_reg)
                begin
                    do_cap     = 1'b1;
                    state_next = ST_RUN;
                    cap_base   = '0;
                    pkt_base   = '0;
                    fill_base  = '0;
                end
            end
            ST_RUN:
            begin
                do_cap = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_cap)
        begin
            cap_inc  = cap_base + dmxrx_pkg::SLOT_W'(1);
            fill_inc = fill_base + dmxrx_pkg::IDX_W'(1);
            step.count = 2'd1;
            step.first.packet_number = pkt_base;
            step.first.byte_index    = fill_base;
            step.first.byte_value    = rx_byte;
            step.first.packet_done   = 1'b0;

            // The trailer of a closed packet always carries the packet that
            // the data byte went into.
            step.second.packet_number = pkt_base;
            step.second.byte_index    = PAYLOAD_IDX;
            step.second.byte_value    = dmxrx_pkg::BYTE_W'(pkt_base);
            step.second.packet_done   = 1'b1;

            cap_next  = cap_inc;
            fill_next = fill_inc;
            pkt_next  = pkt_base;
            if (fill_inc == PAYLOAD_IDX)
            begin
                step.count = 2'd2;
                fill_next  = '0;
                pkt_next   = pkt_base + dmxrx_pkg::PKT_W'(1);
            end
            if (cap_inc >= limit)
            begin
                state_next = ST_IDLE;
                if (fill_next != '0)
                    step.count = 2'd2;
                fill_next = '0;
                pkt_next  = '0;
            end
            step.first.last_of_run  = (step.count == 2'd1);
            step.second.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            cap_reg   <= '0;
            pkt_reg   <= '0;
            fill_reg  <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            cap_reg   <= cap_next;
            pkt_reg   <= pkt_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= dmxrx_pkg::START_ADDRESS_RST;
            channel_count_reg <= dmxrx_pkg::CHANNEL_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dmxrx_pkg::REG_START_ADDRESS: start_address_reg <= cfg_data;
                dmxrx_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/dmx_receiver_packetizer_core.sv */
// A received word is taken into the input register and written into the output queue
// once the queue has room; its output words are offered from the head of the queue.
// Throughput: one received word per cycle while the queue has room; each word yields
// zero, one or two output words; the four-entry queue drains one per cycle on out_ready.
// Reset (rst_n, asynchronous, active low) returns the receiver to idle, clears the
// slot, capture and packet counters, empties the queue and restores the registers
// to start address 1 and channel count 512.
module dmx_receiver_packetizer_core #(
    parameter int PAYLOAD_BYTES = dmxrx_pkg::DEF_PAYLOAD_BYTES,
    parameter int MAX_SLOTS     = dmxrx_pkg::DEF_MAX_SLOTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dmxrx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmxrx_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dmxrx_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                            frame_error,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dmxrx_pkg::PKT_W-1:0]     packet_number,
    output logic [dmxrx_pkg::IDX_W-1:0]     byte_index,
    output logic [dmxrx_pkg::BYTE_W-1:0]    byte_value,
    output logic                            packet_done,
    output logic                            last_of_run
);

    // The input register holds one received word. It is processed in the cycle
    // after it arrives, as long as the output queue can take two more words
    // once this cycle's pop is counted. That keeps the input side moving while
    // earlier words still wait on the output side.
    logic                         in_valid_reg;
    logic [dmxrx_pkg::BYTE_W-1:0] rx_byte_reg;
    logic                         frame_error_reg;

    // Output queue: four words, written at up to two places per cycle and read
    // at the head.
    dmxrx_pkg::res_t  queue_reg [4];
    logic [1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [2:0]       count_reg;
    logic [2:0]       count_after_pop;

    logic             pop;
    logic             process;
    dmxrx_pkg::step_t step;
    dmxrx_pkg::res_t  head;

    assign pop             = out_valid && out_ready;
    assign count_after_pop = count_reg - {2'b00, pop};
    assign process         = in_valid_reg && (count_after_pop <= 3'd2);
    assign in_ready        = !in_valid_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (process)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rx_byte_reg     <= rx_byte;
            frame_error_reg <= frame_error;
        end
    end

    // Frame tracking, slot matching and packet building for the held word.
    dmxrx_ctrl #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .MAX_SLOTS     (MAX_SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fire        (process),
        .rx_byte     (rx_byte_reg),
        .frame_error (frame_error_reg),
        .step        (step)
    );

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            if (step.count != 2'd0)
                queue_reg[wr_ptr_reg] <= step.first;
            if (step.count == 2'd2)
                queue_reg[wr_ptr_reg + 2'd1] <= step.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (process)
            begin
                wr_ptr_reg <= wr_ptr_reg + step.count;
                count_reg  <= count_after_pop + {1'b0, step.count};
            end
            else
            begin
                count_reg <= count_after_pop;
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
        end
    end

    assign head          = queue_reg[rd_ptr_reg];
    assign out_valid     = (count_reg != '0);
    assign packet_number = head.packet_number;
    assign byte_index    = head.byte_index;
    assign byte_value    = head.byte_value;
    assign packet_done   = head.packet_done;
    assign last_of_run   = head.last_of_run;

endmodule

/* rtl/core/dmxrx_checker.sv */
module dmxrx_checker #(
    parameter int PAYLOAD_BYTES = dmxrx_pkg::DEF_PAYLOAD_BYTES
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [dmxrx_pkg::PKT_W-1:0]  packet_number,
    input logic [dmxrx_pkg::IDX_W-1:0]  byte_index,
    input logic [dmxrx_pkg::BYTE_W-1:0] byte_value,
    input logic                         packet_done,
    input logic                         last_of_run
);

    localparam logic [dmxrx_pkg::IDX_W-1:0] PAYLOAD_IDX =
        dmxrx_pkg::IDX_W'(PAYLOAD_BYTES);

    // A stalled output word keeps its value, index and packet number.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_value)
            && $stable(byte_index) && $stable(packet_number))
        else $error("output word changed while stalled");

    // A trailer sits at the trailer index and carries its packet number.
    a_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_done |-> byte_index == PAYLOAD_IDX
            && byte_value == dmxrx_pkg::BYTE_W'(packet_number))
        else $error("malformed trailer word");

    // A trailer is always the final word caused by its input.
    a_trailer_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_done |-> last_of_run)
        else $error("trailer not flagged last");

    // Data words stay inside the payload area.
    a_data_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !packet_done |-> byte_index < PAYLOAD_IDX)
        else $error("data word beyond payload");

endmodule

bind dmx_receiver_packetizer_core dmxrx_checker #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_dmxrx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .packet_number (packet_number),
    .byte_index    (byte_index),
    .byte_value    (byte_value),
    .packet_done   (packet_done),
    .last_of_run   (last_of_run)
);
